[src/rebsa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rebsa_pkg: shared types and constants for the record sorter
// Record, load word and result word layouts, config register codes, FSM states.
// ---------------------------------------------------------------------------
package rebsa_pkg;

	localparam int SCORE_W   = 10;
	localparam int TAG_W     = 8;
	localparam int SUM_W     = 12;
	localparam int CFG_IDX_W = 2;

	// average threshold is compared against the sum, so it is kept scaled by three
	localparam int AVG_MULT = 3;

	localparam logic [SCORE_W-1:0] ENGLISH_THR_RST = SCORE_W'(900);
	localparam logic [SCORE_W-1:0] AVERAGE_THR_RST = SCORE_W'(800);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENGLISH_THR = 2'd0,
		REG_AVERAGE_THR = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [SCORE_W-1:0] first;
		logic [SCORE_W-1:0] second;
		logic [SCORE_W-1:0] english;
	} record_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score_first;
		logic [SCORE_W-1:0] score_second;
		logic [SCORE_W-1:0] score_english;
		logic [TAG_W-1:0]   record_tag;
		logic               last_record;
	} load_word_t;

	typedef struct packed {
		logic [TAG_W-1:0]   out_tag;
		logic [SCORE_W-1:0] out_first;
		logic [SCORE_W-1:0] out_second;
		logic [SCORE_W-1:0] out_english;
		logic [SUM_W-1:0]   score_sum;
		logic               english_high;
		logic               average_high;
		logic               overflowed;
		logic               last_out;
	} result_word_t;

	// sequencer -> output stage
	typedef struct packed {
		logic load;
		logic last;
		logic overflow;
	} emit_ctl_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SORT_RI,
		ST_SORT_CI,
		ST_SORT_CMP,
		ST_SORT_WI,
		ST_EMIT_RD,
		ST_EMIT_LD
	} seq_state_t;

	function automatic logic [SUM_W-1:0] rec_sum(input record_t r);
		rec_sum = SUM_W'(r.first) + SUM_W'(r.second) + SUM_W'(r.english);
	endfunction

endpackage
`default_nettype wire

[src/rebsa_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rebsa_store: record memory
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module rebsa_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic [AW-1:0]      waddr,
	input  wire rebsa_pkg::record_t wdata,
	input  wire logic [AW-1:0]      raddr,
	output rebsa_pkg::record_t      rdata
);

	rebsa_pkg::record_t mem [DEPTH];
	rebsa_pkg::record_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[src/rebsa_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rebsa_seq: load / exchange sort / emit sequencer around the record memory
// Holds record i in a register while sweeping j; swaps write back in place.
// ---------------------------------------------------------------------------
module rebsa_seq #(
	parameter int MAX_RECORDS = 64,
	parameter int IDX_W       = 6,
	parameter int CNT_W       = 7
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load_valid,
	input  wire rebsa_pkg::load_word_t load_word,
	output logic                       load_stall,
	input  wire logic                  slot_free,
	output rebsa_pkg::emit_ctl_t       emit,
	output rebsa_pkg::record_t         rec_data
);

	rebsa_pkg::seq_state_t state_q, state_d;
	logic [CNT_W-1:0]      count_q, count_d;
	logic                  ovf_q, ovf_d;
	logic [IDX_W-1:0]      i_q, i_d;
	logic [IDX_W-1:0]      j_q, j_d;
	logic [IDX_W-1:0]      k_q, k_d;
	rebsa_pkg::record_t    cur_q, cur_d;

	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	rebsa_pkg::record_t    mem_wdata;
	logic [IDX_W-1:0]      mem_raddr;
	rebsa_pkg::record_t    mem_rdata;

	logic                  full;
	rebsa_pkg::record_t    in_rec;

	rebsa_store #(
		.DEPTH (MAX_RECORDS),
		.AW    (IDX_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign full     = (count_q == CNT_W'(MAX_RECORDS));
	assign rec_data = mem_rdata;

	always_comb begin
		in_rec.tag     = load_word.record_tag;
		in_rec.first   = load_word.score_first;
		in_rec.second  = load_word.score_second;
		in_rec.english = load_word.score_english;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rebsa_pkg::ST_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ovf_q   <= ovf_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
	end

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		ovf_d         = ovf_q;
		i_d           = i_q;
		j_d           = j_q;
		k_d           = k_q;
		cur_d         = cur_q;
		mem_we        = 1'b0;
		mem_waddr     = '0;
		mem_wdata     = cur_q;
		mem_raddr     = '0;
		load_stall    = 1'b1;
		emit.load     = 1'b0;
		emit.last     = 1'b0;
		emit.overflow = ovf_q;

		unique case (state_q)
			rebsa_pkg::ST_LOAD: begin
				load_stall = 1'b0;
				if (load_valid) begin
					if (!full) begin
						mem_we    = 1'b1;
						mem_waddr = count_q[IDX_W-1:0];
						mem_wdata = in_rec;
						count_d   = count_q + CNT_W'(1);
					end else begin
						ovf_d = 1'b1;
					end
					if (load_word.last_record) begin
						// two or more records after this one lands -> sort
						if (full || count_q != '0) begin
							i_d     = '0;
							state_d = rebsa_pkg::ST_SORT_RI;
						end else begin
							k_d     = '0;
							state_d = rebsa_pkg::ST_EMIT_RD;
						end
					end
				end
			end
			rebsa_pkg::ST_SORT_RI: begin
				mem_raddr = i_q;
				state_d   = rebsa_pkg::ST_SORT_CI;
			end
			rebsa_pkg::ST_SORT_CI: begin
				cur_d     = mem_rdata;
				mem_raddr = i_q + IDX_W'(1);
				j_d       = i_q + IDX_W'(1);
				state_d   = rebsa_pkg::ST_SORT_CMP;
			end
			rebsa_pkg::ST_SORT_CMP: begin
				// strict greater: equal sums stay put
				if (rebsa_pkg::rec_sum(cur_q) > rebsa_pkg::rec_sum(mem_rdata)) begin
					mem_we    = 1'b1;
					mem_waddr = j_q;
					mem_wdata = cur_q;
					cur_d     = mem_rdata;
				end
				if (CNT_W'(j_q) + CNT_W'(1) == count_q) begin
					state_d = rebsa_pkg::ST_SORT_WI;
				end else begin
					mem_raddr = j_q + IDX_W'(1);
					j_d       = j_q + IDX_W'(1);
				end
			end
			rebsa_pkg::ST_SORT_WI: begin
				mem_we    = 1'b1;
				mem_waddr = i_q;
				mem_wdata = cur_q;
				if (CNT_W'(i_q) + CNT_W'(2) < count_q) begin
					i_d       = i_q + IDX_W'(1);
					mem_raddr = i_q + IDX_W'(1);
					state_d   = rebsa_pkg::ST_SORT_CI;
				end else begin
					k_d     = '0;
					state_d = rebsa_pkg::ST_EMIT_RD;
				end
			end
			rebsa_pkg::ST_EMIT_RD: begin
				if (slot_free) begin
					mem_raddr = k_q;
					state_d   = rebsa_pkg::ST_EMIT_LD;
				end
			end
			rebsa_pkg::ST_EMIT_LD: begin
				emit.load = 1'b1;
				emit.last = (CNT_W'(k_q) + CNT_W'(1) == count_q);
				if (emit.last) begin
					count_d = '0;
					ovf_d   = 1'b0;
					state_d = rebsa_pkg::ST_LOAD;
				end else begin
					k_d     = k_q + IDX_W'(1);
					state_d = rebsa_pkg::ST_EMIT_RD;
				end
			end
			default: begin
				state_d = rebsa_pkg::ST_LOAD;
			end
		endcase
	end

endmodule
`default_nettype wire

[src/record_exchange_sort_by_average_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// record_exchange_sort_by_average_core: record loader and sorter by score sum
// Stores records, exchange-sorts them ascending by score sum on the last
// record, then streams them out with english / average threshold flags.
// ---------------------------------------------------------------------------
//
//  channel  handshake                  word                      moves on
//  -------  -------------------------  ------------------------  -------------------
//  load     load_valid / load_stall    load_word   (38+1 bits)   valid & !stall
//  result   result_valid/result_stall  result_word (54 bits)     valid & !stall
//  config   cfg_valid / cfg_ready      cfg_index, cfg_data       valid & ready
//
//  Records without the last mark are stored back to back while loading; load_stall
//  is raised during sort and emission. The last record starts the sort: for n
//  stored records each outer pass does one load of record i, one compare per later
//  record (one memory read each) and one write-back, so the sort time is set by
//  the single memory read port. Emission then reads each record and loads it into the output register.
//  Reset clears counts and flags and restores the default thresholds; the record memory is not cleared.
//  A stalled result word holds in the output register; emission waits for it.
//
module record_exchange_sort_by_average_core #(
	parameter int MAX_RECORDS = 64
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// load channel
	input  wire logic                               load_valid,
	output logic                                    load_stall,
	input  wire rebsa_pkg::load_word_t              load_word,
	// result channel
	output logic                                    result_valid,
	input  wire logic                               result_stall,
	output rebsa_pkg::result_word_t                 result_word,
	// config channel
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [rebsa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [rebsa_pkg::SCORE_W-1:0]      cfg_data
);

	localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int CNT_W = $clog2(MAX_RECORDS + 1);

	// thresholds; the average one is kept pre-multiplied by three
	logic [rebsa_pkg::SCORE_W-1:0] eng_thr_q;
	logic [rebsa_pkg::SUM_W-1:0]   avg3_thr_q;

	rebsa_pkg::emit_ctl_t          emit;
	rebsa_pkg::record_t            rec_data;
	logic                          slot_free;
	logic [rebsa_pkg::SUM_W-1:0]   sum;

	rebsa_pkg::result_word_t       res_q;
	logic                          res_valid_q;

	// the user must issue config writes only while idle; the block does not enforce this, and there is no backpressure
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_thr_q  <= rebsa_pkg::ENGLISH_THR_RST;
			avg3_thr_q <= rebsa_pkg::SUM_W'(rebsa_pkg::AVERAGE_THR_RST) *
				rebsa_pkg::SUM_W'(rebsa_pkg::AVG_MULT);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rebsa_pkg::REG_ENGLISH_THR: begin
					eng_thr_q <= cfg_data;
				end
				rebsa_pkg::REG_AVERAGE_THR: begin
					avg3_thr_q <= rebsa_pkg::SUM_W'(cfg_data) *
						rebsa_pkg::SUM_W'(rebsa_pkg::AVG_MULT);
				end
				default: begin
					// unmapped index: ignored
				end
			endcase
		end
	end

	// output slot is free next cycle if empty now or being taken now
	assign slot_free = !res_valid_q || !result_stall;

	rebsa_seq #(
		.MAX_RECORDS (MAX_RECORDS),
		.IDX_W       (IDX_W),
		.CNT_W       (CNT_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (load_valid),
		.load_word  (load_word),
		.load_stall (load_stall),
		.slot_free  (slot_free),
		.emit       (emit),
		.rec_data   (rec_data)
	);

	assign sum = rebsa_pkg::rec_sum(rec_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit.load) begin
			res_valid_q <= 1'b1;
		end else if (res_valid_q && !result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			res_q.out_tag      <= rec_data.tag;
			res_q.out_first    <= rec_data.first;
			res_q.out_second   <= rec_data.second;
			res_q.out_english  <= rec_data.english;
			res_q.score_sum    <= sum;
			res_q.english_high <= (rec_data.english >= eng_thr_q);
			res_q.average_high <= (sum >= avg3_thr_q);
			res_q.overflowed   <= emit.overflow;
			res_q.last_out     <= emit.last;
		end
	end

	assign result_valid = res_valid_q;
	assign result_word  = res_q;

endmodule
`default_nettype wire
